/* rtl/ghst_pkg.sv */
`timescale 1ns / 1ps
package ghst_pkg;
   typedef enum logic [2:0] {
      OP_CREATE  = 3'd0,
      OP_DESTROY = 3'd1,
      OP_FLUSH   = 3'd2,
      OP_LOOKUP  = 3'd3,
      OP_SET_OWN = 3'd4,
      OP_GET_OWN = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_FULL    = 2'd2,
      ST_QFULL   = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_READ,
      S_EXEC,
      S_FL_READ,
      S_FL_SLOT,
      S_FL_LAST,
      S_FL_MOVE
   } state_type;

   localparam int TYPE_W = 7;
   // slot count matches the 10-bit handle index
   localparam int SLOTS = 1024;
endpackage

/* rtl/generational_handle_slot_table.sv */
`timescale 1ns / 1ps
// Slot-map handle table. Reset starts a clearing pass over all SLOTS slots
// that builds the free chain, marks slots empty and zeroes the age and owner
// tables; busy is high throughout. Every item then takes read, execute and
// respond steps; flush takes slot, last and move steps per queued slot,
// as one shared set of table read and write ports serves each in turn.
// Results appear for one cycle on rsp_valid and cannot be stalled.
module generational_handle_slot_table import ghst_pkg::*; #(
   parameter int PENDING_DEPTH = 16,
   parameter int AGE_BITS = 11
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_operation,
   input  logic [TYPE_W-1:0]   req_handle_type,
   input  logic [9:0]          req_handle_index,
   input  logic [AGE_BITS-1:0] req_handle_age,
   input  logic [31:0]         req_owner_value,
   input  logic                csr_write,
   input  logic [TYPE_W-1:0]   csr_wdata,
   output logic                rsp_valid,
   output logic [1:0]          rsp_status,
   output logic [TYPE_W-1:0]   rsp_out_type,
   output logic [9:0]          rsp_out_index,
   output logic [AGE_BITS-1:0] rsp_out_age,
   output logic [9:0]          rsp_dense_position,
   output logic [31:0]         rsp_owner_out,
   output logic                rsp_moved,
   output logic [9:0]          rsp_moved_from,
   output logic                rsp_last
);
   localparam int SW = $clog2(SLOTS);
   localparam int CW = SW + 1;
   localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int QW = $clog2(PENDING_DEPTH + 1);
   localparam logic [CW-1:0] NONE = {CW{1'b1}};

   logic [CW-1:0]       dense_mem [SLOTS];
   logic [CW-1:0]       next_mem  [SLOTS];
   logic [AGE_BITS-1:0] age_mem   [SLOTS];
   logic [31:0]         owner_mem [SLOTS];
   logic [SW-1:0]       d2s_mem   [SLOTS];
   logic [SW-1:0]       pend_mem  [PENDING_DEPTH];

   state_type state_ff, state_in;
   logic [TYPE_W-1:0] type_ff;
   logic [CW-1:0] used_ff, used_in, head_ff, head_in, tail_ff, tail_in;
   logic [QW-1:0] pcnt_ff, pcnt_in, k_ff, k_in;
   logic [CW-1:0] clr_ff, clr_in;

   logic [2:0]          op_ff;
   logic [TYPE_W-1:0]   htype_ff;
   logic [9:0]          hidx_ff;
   logic [AGE_BITS-1:0] hage_ff;
   logic [31:0]         own_ff;

   logic [SW-1:0]       ra_ff, ra_in;
   logic [SW-1:0]       da_ff, da_in;
   logic [CW-1:0]       rd_dense_ff, rd_next_ff;
   logic [AGE_BITS-1:0] rd_age_ff;
   logic [31:0]         rd_owner_ff;
   logic [SW-1:0]       rd_d2s_ff, rd_pend_ff;
   logic [PW-1:0]       pa_in;

   logic          dw_en, nw_en, aw_en, ow_en, tw_en, pw_en;
   logic [SW-1:0] dw_a, nw_a, aw_a, ow_a, tw_a;
   logic [CW-1:0] dw_d, nw_d;
   logic [AGE_BITS-1:0] aw_d;
   logic [31:0]   ow_d;
   logic [SW-1:0] tw_d;
   logic [CW-1:0] hole_ff, hole_in, last_ff, last_in;

   logic          rv_in;
   logic [1:0]    st_in;
   logic [TYPE_W-1:0] ot_in;
   logic [9:0]    oi_in, dp_in, mf_in;
   logic [AGE_BITS-1:0] oa_in;
   logic [31:0]   oo_in;
   logic          mv_in, ls_in;

   logic idx_ok, hok;
   assign idx_ok = ({22'd0, hidx_ff} < 32'(SLOTS));
   assign hok = (type_ff != '0) && (htype_ff == type_ff) && idx_ok &&
                (rd_dense_ff != NONE) && (hage_ff == rd_age_ff);

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         type_ff <= TYPE_W'(1);
         used_ff <= '0;
         head_ff <= '0;
         tail_ff <= CW'(SLOTS - 1);
         pcnt_ff <= '0;
         k_ff <= '0;
         clr_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write) type_ff <= csr_wdata;
         used_ff <= used_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         pcnt_ff <= pcnt_in;
         k_ff <= k_in;
         clr_ff <= clr_in;
         rsp_valid <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         op_ff <= req_operation;
         htype_ff <= req_handle_type;
         hidx_ff <= req_handle_index;
         hage_ff <= req_handle_age;
         own_ff <= req_owner_value;
      end
      ra_ff <= ra_in;
      da_ff <= da_in;
      hole_ff <= hole_in;
      last_ff <= last_in;
      rd_dense_ff <= dense_mem[ra_in];
      rd_next_ff  <= next_mem[ra_in];
      rd_age_ff   <= age_mem[ra_in];
      rd_owner_ff <= owner_mem[ra_in];
      rd_d2s_ff   <= d2s_mem[da_in];
      rd_pend_ff  <= pend_mem[pa_in];
      if (dw_en) dense_mem[dw_a] <= dw_d;
      if (nw_en) next_mem[nw_a] <= nw_d;
      if (aw_en) age_mem[aw_a] <= aw_d;
      if (ow_en) owner_mem[ow_a] <= ow_d;
      if (tw_en) d2s_mem[tw_a] <= tw_d;
      if (pw_en) pend_mem[pcnt_ff[PW-1:0]] <= hidx_ff[SW-1:0];
      rsp_status <= st_in;
      rsp_out_type <= ot_in;
      rsp_out_index <= oi_in;
      rsp_out_age <= oa_in;
      rsp_dense_position <= dp_in;
      rsp_owner_out <= oo_in;
      rsp_moved <= mv_in;
      rsp_moved_from <= mf_in;
      rsp_last <= ls_in;
   end

   always_comb begin
      state_in = state_ff;
      used_in = used_ff; head_in = head_ff; tail_in = tail_ff;
      pcnt_in = pcnt_ff; k_in = k_ff; clr_in = clr_ff;
      ra_in = ra_ff; da_in = da_ff; pa_in = k_ff[PW-1:0];
      hole_in = hole_ff; last_in = last_ff;
      dw_en = 1'b0; nw_en = 1'b0; aw_en = 1'b0; ow_en = 1'b0;
      tw_en = 1'b0; pw_en = 1'b0;
      dw_a = ra_ff; nw_a = ra_ff; aw_a = ra_ff; ow_a = ra_ff; tw_a = da_ff;
      dw_d = NONE; nw_d = NONE; aw_d = '0; ow_d = '0; tw_d = ra_ff;
      rv_in = 1'b0; st_in = ST_OK; ot_in = '0; oi_in = '0; oa_in = '0;
      dp_in = '0; oo_in = '0; mv_in = 1'b0; mf_in = '0; ls_in = 1'b1;
      unique case (state_ff)
         S_CLEAR: begin
            dw_en = 1'b1; nw_en = 1'b1; aw_en = 1'b1; ow_en = 1'b1;
            dw_a = clr_ff[SW-1:0]; nw_a = clr_ff[SW-1:0];
            aw_a = clr_ff[SW-1:0]; ow_a = clr_ff[SW-1:0];
            nw_d = (clr_ff == CW'(SLOTS - 1)) ? NONE : clr_ff + CW'(1);
            clr_in = clr_ff + CW'(1);
            if (clr_ff == CW'(SLOTS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               ra_in = (req_operation == OP_CREATE) ? head_ff[SW-1:0]
                                                   : req_handle_index[SW-1:0];
               k_in = '0;
               pa_in = '0;
               state_in = (req_operation == OP_FLUSH) ? S_FL_READ : S_READ;
            end
         end
         S_READ: state_in = S_EXEC;
         S_EXEC: begin
            rv_in = 1'b1;
            state_in = S_IDLE;
            case (op_ff)
               OP_CREATE: begin
                  if (type_ff == '0) st_in = ST_INVALID;
                  else if (head_ff == NONE || rd_next_ff == NONE ||
                           used_ff >= CW'(SLOTS)) st_in = ST_FULL;
                  else begin
                     dw_en = 1'b1; dw_d = used_ff;
                     tw_en = 1'b1; tw_a = used_ff[SW-1:0]; tw_d = ra_ff;
                     nw_en = 1'b1; nw_d = NONE;
                     used_in = used_ff + CW'(1);
                     head_in = rd_next_ff;
                     ot_in = type_ff; oi_in = 10'(ra_ff); oa_in = rd_age_ff;
                     dp_in = 10'(used_ff);
                  end
               end
               OP_DESTROY: begin
                  if (!hok) st_in = ST_INVALID;
                  else if (pcnt_ff >= QW'(PENDING_DEPTH)) st_in = ST_QFULL;
                  else begin
                     pw_en = 1'b1;
                     pcnt_in = pcnt_ff + QW'(1);
                     aw_en = 1'b1; aw_d = rd_age_ff + AGE_BITS'(1);
                  end
               end
               OP_LOOKUP: begin
                  if (!hok) st_in = ST_INVALID;
                  else dp_in = 10'(rd_dense_ff);
               end
               OP_SET_OWN: begin
                  if (!hok) st_in = ST_INVALID;
                  else begin
                     ow_en = 1'b1; ow_d = own_ff;
                  end
               end
               OP_GET_OWN: begin
                  if (!hok) st_in = ST_INVALID;
                  else oo_in = rd_owner_ff;
               end
               default: st_in = ST_INVALID;
            endcase
         end
         S_FL_READ: begin
            if (pcnt_ff == '0) begin
               rv_in = 1'b1;
               state_in = S_IDLE;
            end else state_in = S_FL_SLOT;
         end
         S_FL_SLOT: begin
            ra_in = rd_pend_ff;
            da_in = used_ff[SW-1:0] - SW'(1);
            state_in = S_FL_LAST;
         end
         S_FL_LAST: begin
            hole_in = rd_dense_ff;
            last_in = used_ff - CW'(1);
            state_in = S_FL_MOVE;
            if (rd_dense_ff != NONE && used_ff != '0) begin
               dw_en = 1'b1; dw_d = NONE;
               nw_en = (tail_ff != NONE); nw_a = tail_ff[SW-1:0];
               nw_d = {1'b0, ra_ff};
               tail_in = {1'b0, ra_ff};
               ra_in = rd_d2s_ff;
            end else hole_in = NONE;
         end
         S_FL_MOVE: begin
            rv_in = 1'b1;
            oi_in = 10'(rd_pend_ff);
            ls_in = (k_ff + QW'(1) == pcnt_ff);
            if (hole_ff != NONE) begin
               dp_in = 10'(hole_ff);
               used_in = used_ff - CW'(1);
               if (hole_ff < last_ff) begin
                  tw_en = 1'b1; tw_a = hole_ff[SW-1:0]; tw_d = ra_ff;
                  dw_en = 1'b1; dw_d = hole_ff;
                  mv_in = 1'b1; mf_in = 10'(last_ff);
               end
            end
            k_in = k_ff + QW'(1);
            pa_in = k_in[PW-1:0];
            if (ls_in) begin
               pcnt_in = '0;
               state_in = S_IDLE;
            end else state_in = S_FL_SLOT;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
